// ===== design/tif_pkg.sv =====
`default_nettype none

package tif_pkg;

    // Telnet command codes (RFC 854)
    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_SB   = 8'd250;

    // Option codes that are accepted; ECHO only after WILL, not after DO
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    // Escape parser state, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b000_0001,
        ST_IAC  = 7'b000_0010,
        ST_DONT = 7'b000_0100,
        ST_DO   = 7'b000_1000,
        ST_WONT = 7'b001_0000,
        ST_WILL = 7'b010_0000,
        ST_SB   = 7'b100_0000
    } t_state;

    // Result kind
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_WONT = 2'd2,
        KIND_DONT = 2'd3
    } t_kind;

    // One filtered result
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_result;

endpackage

`default_nettype wire

// ===== design/tif_fsm.sv =====
`default_nettype none

// Escape parser: state register plus the per-byte decode.
module tif_fsm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,  // byte moves on to the result register
    input  wire logic [7:0]       i_byte,
    output tif_pkg::t_result      o_result
);

    tif_pkg::t_state  r_state;
    tif_pkg::t_state  n_state;
    tif_pkg::t_result w_res;

    // Decode one byte against the current escape state
    always_comb begin
        n_state      = r_state;
        w_res.kind   = tif_pkg::KIND_NONE;
        w_res.value  = 8'd0;
        case (r_state)
            tif_pkg::ST_IAC: begin
                if (i_byte == tif_pkg::CODE_IAC) begin
                    w_res.kind  = tif_pkg::KIND_DATA;
                    w_res.value = i_byte;
                    n_state     = tif_pkg::ST_IDLE;
                end else if (i_byte == tif_pkg::CODE_DONT) begin
                    n_state = tif_pkg::ST_DONT;
                end else if (i_byte == tif_pkg::CODE_DO) begin
                    n_state = tif_pkg::ST_DO;
                end else if (i_byte == tif_pkg::CODE_WONT) begin
                    n_state = tif_pkg::ST_WONT;
                end else if (i_byte == tif_pkg::CODE_WILL) begin
                    n_state = tif_pkg::ST_WILL;
                end else if (i_byte == tif_pkg::CODE_SB) begin
                    n_state = tif_pkg::ST_SB;
                end else begin
                    n_state = tif_pkg::ST_IDLE;
                end
            end
            tif_pkg::ST_DONT, tif_pkg::ST_WONT: begin
                n_state = tif_pkg::ST_IDLE;
            end
            tif_pkg::ST_DO: begin
                // refuse every option but BINARY and SGA
                if (i_byte != tif_pkg::OPT_BINARY && i_byte != tif_pkg::OPT_SGA) begin
                    w_res.kind  = tif_pkg::KIND_WONT;
                    w_res.value = i_byte;
                end
                n_state = tif_pkg::ST_IDLE;
            end
            tif_pkg::ST_WILL: begin
                // refuse every option but BINARY, ECHO and SGA
                if (i_byte != tif_pkg::OPT_BINARY && i_byte != tif_pkg::OPT_ECHO &&
                    i_byte != tif_pkg::OPT_SGA) begin
                    w_res.kind  = tif_pkg::KIND_DONT;
                    w_res.value = i_byte;
                end
                n_state = tif_pkg::ST_IDLE;
            end
            tif_pkg::ST_SB: begin
                // skip subnegotiation up to the next IAC
                if (i_byte == tif_pkg::CODE_IAC) begin
                    n_state = tif_pkg::ST_IAC;
                end
            end
            default: begin
                if (i_byte == tif_pkg::CODE_IAC) begin
                    n_state = tif_pkg::ST_IAC;
                end else begin
                    w_res.kind  = tif_pkg::KIND_DATA;
                    w_res.value = i_byte;
                    n_state     = tif_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // State moves only when the byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tif_pkg::ST_IDLE;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

// ===== design/telnet_iac_filter.sv =====
// Receive-side telnet IAC filter, one result transfer per input transfer.
// The result is registered: a byte passes the input register, the combinational
// escape decode and the result register before o_m_tvalid rises.
// Throughput: one byte per cycle unless i_m_tready stalls the result stream.
// Reset: synchronous active-low i_rst_n empties both registers and returns
// the escape parser to idle.
`default_nettype none

module telnet_iac_filter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input stream
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  wire logic       i_s_tlast,   // chunk_end
    // result stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] value
    output logic [1:0]      o_m_tuser,   // [1:0] kind
    output logic            o_m_tlast    // chunk_last
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    tif_pkg::t_result r_out_res;
    logic             r_out_last;

    logic             w_out_free;
    logic             w_advance;
    tif_pkg::t_result w_res;

    // Pipeline flow control
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    tif_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .o_result  (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_res  <= w_res;
            r_out_last <= r_in_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_res.value;
    assign o_m_tuser  = r_out_res.kind;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
